// ===== src/itoa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the integer to ASCII formatter.
// No dependencies.
package itoa_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned CHAR_W = 7;
   localparam int unsigned DIGIT_W = 40;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_X = 7'h78;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;

   localparam logic [3:0] DEC_DIGITS = 4'd10;
   localparam logic [3:0] HEX_DIGITS = 4'd8;

   localparam logic CMD_DECIMAL = 1'b0;
   localparam logic CMD_HEX = 1'b1;

   // Converted digits handed from the converter to the emitter.
   typedef struct packed {
      logic valid;
      logic hex;
      logic neg;
      logic [DIGIT_W-1:0] digits;
   } itoa_load_type;

endpackage

// ===== src/itoa_intf.sv =====
`timescale 1ns / 1ps
// Valid/ready channels of the formatter: request word and response character.
// Depends on itoa_pkg.
interface itoa_req_if;
   logic valid;
   logic ready;
   logic [itoa_pkg::VALUE_W-1:0] value;
   logic command;

   modport source (output valid, output value, output command, input ready);
   modport sink (input valid, input value, input command, output ready);
endinterface

interface itoa_rsp_if;
   logic valid;
   logic ready;
   logic [itoa_pkg::CHAR_W-1:0] character;
   logic last;

   modport source (output valid, output character, output last, input ready);
   modport sink (input valid, input character, input last, output ready);
endinterface

// ===== src/itoa_conv.sv =====
`timescale 1ns / 1ps
// Request intake; bit-serial BCD conversion of decimal words (shift/add-3).
// Depends on itoa_pkg and itoa_req_if.
module itoa_conv (
   input  logic                    clock,
   input  logic                    reset,
   itoa_req_if.sink                req_chan,
   input  logic                    emit_idle,
   output itoa_pkg::itoa_load_type load_out
);
   import itoa_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_HOLD} state_type;

   state_type            state_ff, state_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [VALUE_W-1:0]   bin_ff, bin_in;
   logic [DIGIT_W-1:0]   bcd_ff, bcd_in;
   logic [DIGIT_W-1:0]   bcd_adj;
   logic                 neg_ff, neg_in;
   logic                 hex_ff, hex_in;
   logic [VALUE_W-1:0]   mag;
   logic                 accept;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign mag = req_chan.value[VALUE_W-1] ? (~req_chan.value + 32'd1) : req_chan.value;

   always_comb begin
      for (int i = 0; i < 10; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      neg_in = neg_ff;
      hex_in = hex_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               hex_in = req_chan.command;
               if (req_chan.command == CMD_HEX) begin
                  neg_in = 1'b0;
                  bcd_in = {req_chan.value, 8'h00};
                  state_in = S_HOLD;
               end else begin
                  neg_in = req_chan.value[VALUE_W-1];
                  bin_in = mag;
                  bcd_in = '0;
                  cnt_in = 5'd31;
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            bcd_in = {bcd_adj[DIGIT_W-2:0], bin_ff[VALUE_W-1]};
            bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (emit_idle) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
      hex_ff <= hex_in;
   end

   always_comb begin
      load_out.valid = (state_ff == S_HOLD);
      load_out.hex = hex_ff;
      load_out.neg = neg_ff;
      load_out.digits = bcd_ff;
   end

   a_dec_start: assert property (@(posedge clock) disable iff (reset)
      accept && (req_chan.command == CMD_DECIMAL) |=> state_ff == S_SHIFT && cnt_ff == 5'd31)
      else $error("decimal transfer did not start conversion");
   a_hex_start: assert property (@(posedge clock) disable iff (reset)
      accept && (req_chan.command == CMD_HEX) |=> state_ff == S_HOLD)
      else $error("hex transfer did not go straight to hold");
   a_shift_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT && cnt_ff == 5'd0 |=> state_ff == S_HOLD)
      else $error("conversion overran 32 shifts");

endmodule

// ===== src/itoa_emit.sv =====
`timescale 1ns / 1ps
// Character emitter: prefix, then one digit nibble per cycle while the output is not stalled, leading zeros skipped.
// Depends on itoa_pkg and itoa_rsp_if.
module itoa_emit (
   input  logic                    clock,
   input  logic                    reset,
   input  itoa_pkg::itoa_load_type load_in,
   output logic                    emit_idle,
   itoa_rsp_if.source              rsp_chan
);
   import itoa_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_MINUS, S_ZERO, S_X, S_DIGIT} state_type;

   state_type           state_ff, state_in;
   logic [DIGIT_W-1:0]  dig_ff, dig_in;
   logic [3:0]          left_ff, left_in;
   logic                started_ff, started_in;
   logic                out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic                last_ff, last_in;
   logic                can_put;
   logic                put_fire;
   logic [CHAR_W-1:0]   emit_char;
   logic                put_last;
   logic [3:0]          nib;
   logic                final_nib;
   logic                want;

   function automatic logic [CHAR_W-1:0] nib_char(input logic [3:0] n);
      if (n < 4'd10) begin
         return CHAR_ZERO + {3'd0, n};
      end
      return CHAR_UPPER_A + {3'd0, n} - 7'd10;
   endfunction

   assign can_put = !out_valid_ff || rsp_chan.ready;
   assign nib = dig_ff[DIGIT_W-1 -: 4];
   assign final_nib = (left_ff == 4'd1);
   assign want = (nib != 4'd0) || started_ff || final_nib;
   assign emit_idle = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      dig_in = dig_ff;
      left_in = left_ff;
      started_in = started_ff;
      put_fire = 1'b0;
      emit_char = CHAR_ZERO;
      put_last = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (load_in.valid) begin
               dig_in = load_in.digits;
               left_in = load_in.hex ? HEX_DIGITS : DEC_DIGITS;
               started_in = 1'b0;
               if (load_in.hex) begin
                  state_in = S_ZERO;
               end else if (load_in.neg) begin
                  state_in = S_MINUS;
               end else begin
                  state_in = S_DIGIT;
               end
            end
         end
         S_MINUS: begin
            if (can_put) begin
               put_fire = 1'b1;
               emit_char = CHAR_MINUS;
               state_in = S_DIGIT;
            end
         end
         S_ZERO: begin
            if (can_put) begin
               put_fire = 1'b1;
               emit_char = CHAR_ZERO;
               state_in = S_X;
            end
         end
         S_X: begin
            if (can_put) begin
               put_fire = 1'b1;
               emit_char = CHAR_X;
               state_in = S_DIGIT;
            end
         end
         S_DIGIT: begin
            if (!want || can_put) begin
               put_fire = want;
               emit_char = nib_char(nib);
               put_last = final_nib;
               started_in = started_ff || want;
               dig_in = {dig_ff[DIGIT_W-5:0], 4'h0};
               left_in = left_ff - 4'd1;
               if (final_nib) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      char_in = char_ff;
      last_in = last_ff;
      if (put_fire) begin
         out_valid_in = 1'b1;
         char_in = emit_char;
         last_in = put_last;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
      dig_ff <= dig_in;
      left_ff <= left_in;
      started_ff <= started_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.character = char_ff;
   assign rsp_chan.last = last_ff;

   a_load_taken: assert property (@(posedge clock) disable iff (reset)
      load_in.valid && state_ff == S_IDLE |=> state_ff != S_IDLE)
      else $error("pending digits not taken by idle emitter");
   a_prefix_not_last: assert property (@(posedge clock) disable iff (reset)
      put_fire && (state_ff == S_MINUS || state_ff == S_ZERO || state_ff == S_X)
      |-> !put_last)
      else $error("prefix character marked last");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      put_fire && put_last |=> state_ff == S_IDLE)
      else $error("emitter busy after last character");

endmodule

// ===== src/integer_to_ascii_formatter.sv =====
`timescale 1ns / 1ps
// Top level of the integer to ASCII formatter: converter feeding the emitter.
// Depends on itoa_pkg, itoa_intf, itoa_conv and itoa_emit.
//
//   channel   dir  payload                        transfer
//   req_chan  in   value[31:0], command           valid && ready
//   rsp_chan  out  character[6:0], last           valid && ready
//
// Decimal: the BCD converter shifts through all 32 value bits, then hands the
// digits over; the emitter puts out '-' for a negative value and steps through
// the 10 digit nibbles into the output register, skipping leading zeros.
// Hex: the word goes straight to hold, then "0x" and 8 nibbles, again skipping
// leading zeros. A new word is taken once the previous digits move to the
// emitter, so conversion overlaps emission of the prior word.
// Synchronous active-high reset clears control state only.
// A stalled rsp_chan holds the output register and pauses the emitter before its next character.
module integer_to_ascii_formatter (
   input  logic       clock,
   input  logic       reset,
   itoa_req_if.sink   req_chan,
   itoa_rsp_if.source rsp_chan
);
   import itoa_pkg::*;

   itoa_load_type load;
   logic          emit_idle;

   itoa_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .emit_idle (emit_idle),
      .load_out  (load)
   );

   itoa_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load_in   (load),
      .emit_idle (emit_idle),
      .rsp_chan  (rsp_chan)
   );

endmodule
